[rtl/sspq_pkg.sv]
// ---------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants of the sorted priority queue.
// ---------------------------------------------------------------------------
package sspq_pkg;

  localparam int unsigned DEFAULT_DEPTH = 64;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned LIMIT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_WINSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEQUEUE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 16'sh7FFF;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

[rtl/sspq_in_if.sv]
// ---------------------------------------------------------------------------
// sspq_in_if
// Request channel: operation kind, value and weight.
// ---------------------------------------------------------------------------
interface sspq_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [sspq_pkg::KIND_W-1:0]              kind;
  logic signed [sspq_pkg::VALUE_W-1:0]      item_value;
  logic signed [sspq_pkg::WEIGHT_W-1:0]     item_weight;

  modport source (output valid, kind, item_value, item_weight, input ready);
  modport sink   (input valid, kind, item_value, item_weight, output ready);
endinterface

[rtl/sspq_out_if.sv]
// ---------------------------------------------------------------------------
// sspq_out_if
// Response channel: value, status, search hit and entry count.
// ---------------------------------------------------------------------------
interface sspq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sspq_pkg::VALUE_W-1:0]  result_value;
  logic [sspq_pkg::STATUS_W-1:0]        status;
  logic                                 found;
  logic [sspq_pkg::COUNT_W-1:0]         entry_count;

  modport source (output valid, result_value, status, found, entry_count, input ready);
  modport sink   (input valid, result_value, status, found, entry_count, output ready);
endinterface

[rtl/sspq_ctrl.sv]
// ---------------------------------------------------------------------------
// sspq_ctrl
// Two-state sequencer: capture a request, then commit it into the output
// register once that register is free.
// ---------------------------------------------------------------------------
module sspq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output sspq_pkg::cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic ovalid_q, ovalid_d;
  logic capture, commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign capture     = in_valid_i && in_ready_o;
  assign commit      = (state_q == ST_EXEC) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign cmd_o       = '{capture: capture, commit: commit};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (capture) state_d = ST_EXEC;
      ST_EXEC: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (commit) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

[rtl/sspq_dp.sv]
// ---------------------------------------------------------------------------
// sspq_dp
// Shift-register queue datapath: per-cell compare on capture, shift and
// result register on commit.
// ---------------------------------------------------------------------------
module sspq_dp #(
  parameter int unsigned DEPTH = sspq_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sspq_pkg::LIMIT_W-1:0]         cfg_wdata_i,
  input  sspq_pkg::cmd_t                       cmd_i,
  input  logic [sspq_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [sspq_pkg::VALUE_W-1:0]  value_i,
  input  logic signed [sspq_pkg::WEIGHT_W-1:0] weight_i,
  output logic signed [sspq_pkg::VALUE_W-1:0]  result_value_o,
  output logic [sspq_pkg::STATUS_W-1:0]        status_o,
  output logic                                 found_o,
  output logic [sspq_pkg::COUNT_W-1:0]         entry_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > sspq_pkg::LIMIT_W) ? CntW : sspq_pkg::LIMIT_W;
  localparam int unsigned OutW = (CntW > sspq_pkg::COUNT_W) ? CntW : sspq_pkg::COUNT_W;

  logic signed [sspq_pkg::VALUE_W-1:0]  cval_q [DEPTH];
  logic signed [sspq_pkg::WEIGHT_W-1:0] cwgt_q [DEPTH];
  logic [CntW-1:0]                      cnt_q, cnt_d;
  logic signed [sspq_pkg::WEIGHT_W-1:0] last_q, last_d;
  logic [sspq_pkg::LIMIT_W-1:0]         limit_q;

  logic [sspq_pkg::KIND_W-1:0]          kind_q;
  logic signed [sspq_pkg::VALUE_W-1:0]  ival_q;
  logic signed [sspq_pkg::WEIGHT_W-1:0] iwgt_q;
  logic [DEPTH-1:0]                     vec_q, vec_d;

  logic [CmpW-1:0]                      lim;
  logic                                 full, empty, is_ins, do_ins, do_deq;
  logic signed [sspq_pkg::WEIGHT_W-1:0] new_w;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      vec_d[i] = CntW'(i) < cnt_q;
      if (kind_i == sspq_pkg::KIND_WINSERT) vec_d[i] = vec_d[i] && (cwgt_q[i] <= weight_i);
      else if (kind_i == sspq_pkg::KIND_SEARCH) vec_d[i] = vec_d[i] && (cval_q[i] == value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      ival_q <= value_i;
      iwgt_q <= weight_i;
      vec_q  <= vec_d;
    end
  end

  assign lim = (CmpW'(limit_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(limit_q);
  assign full   = CmpW'(cnt_q) >= lim;
  assign empty  = (cnt_q == '0);
  assign is_ins = (kind_q == sspq_pkg::KIND_WINSERT) || (kind_q == sspq_pkg::KIND_APPEND);
  assign do_ins = cmd_i.commit && is_ins && !full;
  assign do_deq = cmd_i.commit && (kind_q == sspq_pkg::KIND_DEQUEUE) && !empty;

  always_comb begin
    if (kind_q == sspq_pkg::KIND_WINSERT) new_w = iwgt_q;
    else if (empty) new_w = '0;
    else if (last_q == sspq_pkg::WEIGHT_MAX) new_w = sspq_pkg::WEIGHT_MAX;
    else new_w = last_q + 16'sd1;
  end

  always_comb begin
    cnt_d  = cnt_q;
    last_d = last_q;
    if (do_ins) begin
      cnt_d = cnt_q + CntW'(1);
      if (empty || new_w > last_q) last_d = new_w;
    end else if (do_deq) begin
      cnt_d = cnt_q - CntW'(1);
    end else if (cmd_i.commit && kind_q == sspq_pkg::KIND_CLEAR) begin
      cnt_d = '0;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (do_ins && !vec_q[g]) begin
        if (g == 0 || vec_q[(g == 0) ? 0 : g-1]) begin
          cval_q[g] <= ival_q;
          cwgt_q[g] <= new_w;
        end else begin
          cval_q[g] <= cval_q[(g == 0) ? 0 : g-1];
          cwgt_q[g] <= cwgt_q[(g == 0) ? 0 : g-1];
        end
      end else if (do_deq && g < DEPTH - 1) begin
        cval_q[g] <= cval_q[(g < DEPTH - 1) ? g+1 : g];
        cwgt_q[g] <= cwgt_q[(g < DEPTH - 1) ? g+1 : g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      limit_q <= sspq_pkg::LIMIT_RESET;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (cmd_i.commit) begin
      result_value_o <= '0;
      status_o       <= sspq_pkg::STATUS_OK;
      found_o        <= 1'b0;
      entry_count_o  <= sspq_pkg::COUNT_W'(OutW'(cnt_d));
      case (kind_q)
        sspq_pkg::KIND_WINSERT, sspq_pkg::KIND_APPEND: begin
          if (full) status_o <= sspq_pkg::STATUS_FULL;
        end
        sspq_pkg::KIND_DEQUEUE, sspq_pkg::KIND_PEEK: begin
          if (empty) status_o <= sspq_pkg::STATUS_EMPTY;
          else result_value_o <= cval_q[0];
        end
        sspq_pkg::KIND_SEARCH: found_o <= |vec_q;
        default: ;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(DEPTH) >= cnt_q) else $error("entry count above depth");
  a_ins_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> cnt_q == $past(cnt_q) + CntW'(1)) else $error("insert did not grow count");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.capture && cmd_i.commit)) else $error("capture and commit together");

endmodule

[rtl/stable_sorted_priority_queue.sv]
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue kept sorted by ascending weight, ties in arrival order.
// ---------------------------------------------------------------------------
// Each request is captured, then committed: capture compares it against
// every stored cell in parallel and registers the per-cell result; commit,
// once the response register is free, shifts the cell array and loads the
// response register. No new request is taken until the last is committed;
// the response register holds one finished response while the next request
// is in flight. capacity_limit is written through cfg_we_i/cfg_wdata_i.
module stable_sorted_priority_queue #(
  parameter int unsigned DEPTH = sspq_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sspq_pkg::LIMIT_W-1:0] cfg_wdata_i,
  sspq_in_if.sink                      in_i,
  sspq_out_if.source                   out_o
);

  sspq_pkg::cmd_t cmd;

  sspq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  sspq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .kind_i         (in_i.kind),
    .value_i        (in_i.item_value),
    .weight_i       (in_i.item_weight),
    .result_value_o (out_o.result_value),
    .status_o       (out_o.status),
    .found_o        (out_o.found),
    .entry_count_o  (out_o.entry_count)
  );

endmodule
